// ===== src/ktor_pkg.sv =====
// ----------------------------------------------------------------------------
// ktor_pkg
// Shared types and constants of the keyed table with oldest-entry replacement.
// ----------------------------------------------------------------------------
package ktor_pkg;

	// Table geometry
	localparam int ENTRIES      = 16;
	localparam int PAYLOAD_BITS = 64;
	localparam int IDX_W        = $clog2(ENTRIES);

	// Fixed field widths
	localparam int ADDR_W    = 24;
	localparam int STAMP_W   = 32;
	localparam int REC_PLD_W = 64;
	localparam int SLOT_W    = 4;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [STAMP_W-1:0]      stamp_t;
	typedef logic [PAYLOAD_BITS-1:0] pld_t;

	// Which case produced the write
	typedef enum logic [1:0] {
		ACT_UPDATE = 2'd0,
		ACT_FILL   = 2'd1,
		ACT_EVICT  = 2'd2
	} action_t;

	// Input record beat
	typedef struct packed {
		logic [ADDR_W-1:0]    device_address;
		logic [STAMP_W-1:0]   stamp;
		logic [REC_PLD_W-1:0] record_payload;
	} rec_t;

	// Result beat
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		action_t           action;
	} res_t;

	// Slot choice handed from the scan unit to the sequencer
	typedef struct packed {
		idx_t    slot;
		action_t action;
	} pick_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

endpackage

// ===== src/ktor_rec_if.sv =====
// ----------------------------------------------------------------------------
// ktor_rec_if
// Valid/ready channel carrying one input record per beat.
// ----------------------------------------------------------------------------
interface ktor_rec_if;
	import ktor_pkg::*;

	logic valid;
	logic ready;
	rec_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/ktor_res_if.sv =====
// ----------------------------------------------------------------------------
// ktor_res_if
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface ktor_res_if;
	import ktor_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/ktor_ram.sv =====
// ----------------------------------------------------------------------------
// ktor_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktor_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/ktor_table.sv =====
// ----------------------------------------------------------------------------
// ktor_table
// Address and stamp store of the table, cleared at reset, one write port and
// one read port indexed by the walk counter.
// ----------------------------------------------------------------------------
module ktor_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           we,
	input  ktor_pkg::idx_t   waddr,
	input  ktor_pkg::addr_t  wr_address,
	input  ktor_pkg::stamp_t wr_stamp,
	input  ktor_pkg::idx_t   raddr,
	output ktor_pkg::addr_t  rd_address,
	output ktor_pkg::stamp_t rd_stamp
);
	import ktor_pkg::*;

	addr_t  address_q [ENTRIES];
	stamp_t stamp_q   [ENTRIES];

	// Clear every entry on reset, write one entry per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				address_q[i] <= '0;
				stamp_q[i]   <= '0;
			end
		end else if (we) begin
			address_q[waddr] <= wr_address;
			stamp_q[waddr]   <= wr_stamp;
		end
	end

	// Select the entry under the walk counter
	assign rd_address = address_q[raddr];
	assign rd_stamp   = stamp_q[raddr];
endmodule

// ===== src/ktor_scan.sv =====
// ----------------------------------------------------------------------------
// ktor_scan
// Compare unit that looks at one table entry per cycle while step is high and
// keeps the first matching, first empty and oldest entry seen so far.
// ----------------------------------------------------------------------------
module ktor_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             step,
	input  ktor_pkg::idx_t   idx,
	input  ktor_pkg::addr_t  key,
	input  ktor_pkg::addr_t  ent_address,
	input  ktor_pkg::stamp_t ent_stamp,
	output ktor_pkg::pick_t  pick
);
	import ktor_pkg::*;

	logic   match_found_q;
	idx_t   match_idx_q;
	logic   empty_found_q;
	idx_t   empty_idx_q;
	stamp_t min_stamp_q;
	idx_t   min_idx_q;

	logic ent_empty;
	logic ent_match;
	logic ent_older;

	// Compare the current entry
	assign ent_empty = (ent_stamp == '0);
	assign ent_match = !ent_empty && (ent_address == key);
	assign ent_older = (idx == '0) || (ent_stamp < min_stamp_q);

	// Track the candidates; first hit wins, strict compare keeps lowest index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (start) begin
			match_found_q <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (step) begin
			if (ent_match && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (ent_empty && !empty_found_q) begin
				empty_found_q <= 1'b1;
			end
		end
	end

	// Candidate indexes and oldest stamp
	always_ff @(posedge clk) begin
		if (step) begin
			if (ent_match && !match_found_q) begin
				match_idx_q <= idx;
			end
			if (ent_empty && !empty_found_q) begin
				empty_idx_q <= idx;
			end
			if (ent_older) begin
				min_stamp_q <= ent_stamp;
				min_idx_q   <= idx;
			end
		end
	end

	// Choose by priority: match, then empty, then oldest
	always_comb begin
		if (match_found_q) begin
			pick.slot   = match_idx_q;
			pick.action = ACT_UPDATE;
		end else if (empty_found_q) begin
			pick.slot   = empty_idx_q;
			pick.action = ACT_FILL;
		end else begin
			pick.slot   = min_idx_q;
			pick.action = ACT_EVICT;
		end
	end

	// A first match on an occupied entry sets the found flag and records its index
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && !match_found_q && ent_match) |=> match_found_q && match_idx_q == $past(idx))
		else $error("match index not captured");

	// Start clears both found flags
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (!match_found_q && !empty_found_q))
		else $error("scan flags not cleared on start");

	// An empty entry seen means the pick can no longer be an eviction
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && ent_empty) |=> (pick.action != ACT_EVICT))
		else $error("eviction chosen with an empty entry present");
endmodule

// ===== src/keyed_table_oldest_replace_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_table_oldest_replace_unit
// Keyed record table with update, fill and replace-oldest policy.
// ----------------------------------------------------------------------------
// Each record is handled in steps: the sequencer accepts it in the idle
// state, the shared compare unit walks the table one entry per cycle, and
// the write state writes the chosen entry and loads the result register.
// The records channel is ready only while the sequencer is idle. A finished
// result sits in an output register until taken, and the next record is
// accepted meanwhile; a further write waits only if that register is still
// full. The table is empty right out of reset, with no clearing pass.
// ----------------------------------------------------------------------------
module keyed_table_oldest_replace_unit (
	input  logic       clk,
	input  logic       arst_n,
	ktor_rec_if.sink   records,
	ktor_res_if.source results
);
	import ktor_pkg::*;

	state_t state_q;
	state_t state_d;
	idx_t   cnt_q;
	addr_t  key_q;
	stamp_t stamp_q;
	pld_t   payload_q;
	logic   res_valid_q;
	res_t   res_q;

	logic   rec_accept;
	logic   scan_start;
	logic   scan_step;
	logic   tbl_we;
	logic   last_entry;
	addr_t  ent_address;
	stamp_t ent_stamp;
	pick_t  pick;

	assign rec_accept = records.valid && records.ready;
	assign last_entry = (cnt_q == idx_t'(ENTRIES - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rec_accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_entry) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!res_valid_q || results.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		records.ready = 1'b0;
		scan_start    = 1'b0;
		scan_step     = 1'b0;
		tbl_we        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				records.ready = 1'b1;
				scan_start    = records.valid;
			end
			ST_SCAN: begin
				scan_step = 1'b1;
			end
			ST_WRITE: begin
				tbl_we = !res_valid_q || results.ready;
			end
			default: begin
				records.ready = 1'b0;
			end
		endcase
	end

	// State and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (rec_accept) begin
				cnt_q <= '0;
			end else if (scan_step && !last_entry) begin
				cnt_q <= cnt_q + idx_t'(1);
			end
		end
	end

	// Hold the accepted record
	always_ff @(posedge clk) begin
		if (rec_accept) begin
			key_q     <= records.data.device_address;
			stamp_q   <= records.data.stamp;
			payload_q <= records.data.record_payload[PAYLOAD_BITS-1:0];
		end
	end

	// Result register: load on write, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tbl_we) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			res_q.slot   <= SLOT_W'(pick.slot);
			res_q.action <= pick.action;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	// Address and stamp store
	ktor_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.we         (tbl_we),
		.waddr      (pick.slot),
		.wr_address (key_q),
		.wr_stamp   (stamp_q),
		.raddr      (cnt_q),
		.rd_address (ent_address),
		.rd_stamp   (ent_stamp)
	);

	// Shared compare unit
	ktor_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.step        (scan_step),
		.idx         (cnt_q),
		.key         (key_q),
		.ent_address (ent_address),
		.ent_stamp   (ent_stamp),
		.pick        (pick)
	);

	// Payload store
	ktor_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (ENTRIES)
	) u_payload_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (pick.slot),
		.wdata (payload_q),
		.raddr (cnt_q),
		.rdata ()
	);

	// An accepted beat starts a walk from entry zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rec_accept |=> (state_q == ST_SCAN && cnt_q == '0))
		else $error("walk did not start at entry zero");

	// The walk ends at the last entry and goes to write
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && last_entry) |=> (state_q == ST_WRITE))
		else $error("walk did not end at the last entry");

	// A table write presents its slot on the result channel
	assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |=> (results.valid && results.data.slot == SLOT_W'($past(pick.slot))))
		else $error("result does not match written slot");
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed record table with oldest-entry replacement.
// A directed sequence walks fill, update, zero-stamp and eviction cases, then
// random phases drive records from small address pools so that the table
// fills, matches and evicts often. A tracker class mirrors the table, predicts
// slot and action for every accepted record, and checks each result beat.
// ----------------------------------------------------------------------------
module testbench;
	import ktor_pkg::*;

	localparam int RESET_CYCLES  = 11;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 2 * (ENTRIES + 2) + 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 175;
	localparam int POOL_MAX      = 48;

	// Mirror of the table; predicts where each record lands
	class table_tracker;
		addr_t  entry_addr [ENTRIES];
		stamp_t entry_stamp [ENTRIES];
		res_t   expected_writes [$];
		int     mismatches;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				entry_addr[i]  = '0;
				entry_stamp[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void note_record(rec_t r);
			int      pick;
			action_t act;
			bit      found;
			stamp_t  oldest;
			res_t    w;
			pick  = 0;
			act   = ACT_EVICT;
			found = 1'b0;
			// Look for the lowest occupied entry with the same address
			for (int i = 0; i < ENTRIES && !found; i++) begin
				if (entry_stamp[i] != '0 && entry_addr[i] == r.device_address) begin
					pick  = i;
					act   = ACT_UPDATE;
					found = 1'b1;
				end
			end
			// Otherwise take the lowest empty entry
			for (int i = 0; i < ENTRIES && !found; i++) begin
				if (entry_stamp[i] == '0) begin
					pick  = i;
					act   = ACT_FILL;
					found = 1'b1;
				end
			end
			// Table full: replace the smallest stamp, lowest index on a tie
			if (!found) begin
				oldest = entry_stamp[0];
				pick   = 0;
				for (int i = 1; i < ENTRIES; i++) begin
					if (entry_stamp[i] < oldest) begin
						oldest = entry_stamp[i];
						pick   = i;
					end
				end
				act = ACT_EVICT;
			end
			entry_addr[pick]  = r.device_address;
			entry_stamp[pick] = r.stamp;
			w.slot   = pick[SLOT_W-1:0];
			w.action = act;
			expected_writes.push_back(w);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_writes.size() == 0) begin
				$error("result beat with no record pending: slot %0d action %0d",
					got.slot, got.action);
				mismatches++;
				return;
			end
			want = expected_writes.pop_front();
			if (got.slot !== want.slot) begin
				$error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
				mismatches++;
			end
			if (got.action !== want.action) begin
				$error("action mismatch: expected %0d, actual %0d",
					want.action, got.action);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected_writes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   stall_left;
	int   idle_cycles;

	table_tracker tracker;

	ktor_rec_if records ();
	ktor_res_if results ();

	keyed_table_oldest_replace_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.records (records),
		.results (results)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Gap length: mostly none or short, a few long; none in calm stretches
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Drive one record beat after a random gap and hold it until accepted
	task automatic send_record(addr_t a, stamp_t s, logic [REC_PLD_W-1:0] p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			records.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		records.valid <= 1'b1;
		records.data  <= {a, s, p};
		do @(posedge clk); while (!records.ready);
		tracker.note_record(records.data);
	endtask

	// Result side: stall the ready line in random runs
	initial begin
		results.ready = 1'b0;
		stall_left    = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				results.ready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else begin
				results.ready <= 1'b1;
				stall_left    <= pick_gap();
			end
		end
	end

	// Check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready)
			tracker.check_result(results.data);
	end

	// Watchdog: end the run if no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((records.valid && records.ready) || (results.valid && results.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("keyed_table_oldest_replace_unit test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Main sequence
	initial begin
		addr_t  pool [POOL_MAX];
		int     pool_n;
		int     r;
		addr_t  a;
		stamp_t s;

		tracker       = new();
		calm          = 1'b1;
		arst_n        = 1'b0;
		records.valid = 1'b0;
		records.data  = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Address zero must not match the cleared entries: fill slot 0
		send_record(24'h000000, 32'd1, 64'h0);
		send_record(24'hFFFFFF, 32'hFFFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		// Update a live entry
		send_record(24'h000000, 32'd5, {$urandom, $urandom});
		// Zero stamp empties the matched entry; the same address then fills it
		send_record(24'hFFFFFF, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA);
		send_record(24'hFFFFFF, 32'd7, 64'h5555_5555_5555_5555);
		// Zero stamp on a new address leaves the filled entry empty
		send_record(24'h123456, 32'd0, {$urandom, $urandom});
		// Fill the rest with equal stamps
		for (int i = 0; i < ENTRIES - 2; i++)
			send_record(addr_t'(24'h000100 + i), 32'd3, {$urandom, $urandom});
		// Full table: evict the lowest of the tied oldest, then the next
		send_record(24'hABCDEF, 32'hFFFFFFFF, 64'h0);
		send_record(24'h5A5A5A, 32'd2, 64'hFFFF_FFFF_FFFF_FFFF);
		// Update still wins once the table is full
		send_record(24'h000000, 32'd9, {$urandom, $urandom});

		// Random phases over small address pools
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm   = (ph % 3 == 1);
			pool_n = $urandom_range(4, 40);
			for (int k = 0; k < pool_n; k++)
				pool[k] = addr_t'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					a = pool[$urandom_range(0, pool_n - 1)];
				else if (r < 83)
					a = 24'hFFFFFF;
				else if (r < 86)
					a = 24'h000000;
				else
					a = addr_t'($urandom);
				r = $urandom_range(0, 99);
				if (r < 8)
					s = '0;
				else if (r < 30)
					s = $urandom_range(1, 4);
				else if (r < 35)
					s = '1;
				else if (r < 38)
					s = 32'd1;
				else
					s = $urandom;
				send_record(a, s, {$urandom, $urandom});
			end
		end

		// Drop valid and drain
		@(negedge clk);
		records.valid <= 1'b0;
		calm = 1'b1;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("keyed_table_oldest_replace_unit test passed");
		else
			$display("keyed_table_oldest_replace_unit test failed");
		$finish;
	end

endmodule
